FILE: design/mmt_pkg.sv
package mmt_pkg;

  // store geometry
  localparam int MAX_VALUES     = 1024;
  localparam int VALS_PER_BLOCK = 32;
  localparam int COUNT_BITS     = 16;
  localparam int NUM_BLOCKS     = (MAX_VALUES + VALS_PER_BLOCK - 1) / VALS_PER_BLOCK;

  localparam int VAL_W   = $clog2(MAX_VALUES);
  localparam int OFS_W   = $clog2(VALS_PER_BLOCK);
  localparam int BLK_W   = $clog2(NUM_BLOCKS);
  localparam int OCC_W   = $clog2(VALS_PER_BLOCK + 1);
  localparam int LIMIT_W = 10;
  localparam int ITEM_W  = 16;
  localparam int MEX_W   = 11;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // input actions
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_RANGE  = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;
  localparam logic [1:0] STAT_SAT    = 2'd3;

  // classified command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_RANGE  = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [ITEM_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [MEX_W-1:0] mex;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] value;
  } cmd_t;

  function automatic logic [VAL_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (int'(v) >= MAX_VALUES) begin
      r = VAL_W'(MAX_VALUES - 1);
    end else begin
      r = VAL_W'(v);
    end
    return r;
  endfunction

  localparam logic [VAL_W-1:0] LIMIT_RESET = clamp_limit(LIMIT_W'(1023));

endpackage

FILE: design/mmt_ram.sv
module mmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/mmt_front.sv
module mmt_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  mmt_pkg::in_item_t            in_item,
  input  logic [mmt_pkg::VAL_W-1:0]    value_limit,
  input  logic                         clearing,
  output logic                         cmd_valid,
  output mmt_pkg::cmd_t                cmd,
  input  logic                         cmd_take
);
  import mmt_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cls;
  logic       accept;
  logic       take;
  logic       out_of_range;

  // classify the item against the current limit
  always_comb begin
    out_of_range = in_item.item_value > {{(ITEM_W - VAL_W){1'b0}}, value_limit};
    cls.value    = in_item.item_value[VAL_W-1:0];
    case (in_item.action)
      ACT_ADD:    cls.op = out_of_range ? CMD_RANGE : CMD_ADD;
      ACT_REMOVE: cls.op = out_of_range ? CMD_RANGE : CMD_REMOVE;
      ACT_QUERY:  cls.op = CMD_QUERY;
      default:    cls.op = CMD_QUERY;
    endcase
  end

  assign full      = (fill == 2'd2) || clearing;
  assign accept    = push && !full;
  assign cmd_valid = fill != 2'd0;
  assign take      = cmd_take && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      if (accept && !take) begin
        fill <= fill + 2'd1;
      end else if (take && !accept) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

FILE: design/mmt_back.sv
module mmt_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [mmt_pkg::VAL_W-1:0] value_limit,
  output logic                      clearing,
  input  logic                      cmd_valid,
  input  mmt_pkg::cmd_t             cmd,
  output logic                      cmd_take,
  output logic                      empty,
  input  logic                      pop,
  output mmt_pkg::out_item_t        out_item
);
  import mmt_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_SCANB  = 3'd3;
  localparam logic [2:0] S_SCANV  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]            state;
  logic [VAL_W-1:0]      clr_cnt;
  logic [1:0]            cur_op;
  logic [VAL_W-1:0]      cur_val;
  logic [1:0]            status;
  logic [BLK_W:0]        blk;
  logic                  blk_chk_valid;
  logic [BLK_W-1:0]      blk_chk;
  logic [BLK_W-1:0]      base;
  logic [OCC_W-1:0]      span;
  logic [OCC_W:0]        k;
  logic                  k_chk_valid;
  logic [OFS_W-1:0]      k_chk;
  logic [MEX_W-1:0]      mex;
  logic                  out_valid;

  logic                  cnt_we;
  logic [VAL_W-1:0]      cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [VAL_W-1:0]      cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  occ_we;
  logic [BLK_W-1:0]      occ_waddr;
  logic [OCC_W-1:0]      occ_wdata;
  logic [BLK_W-1:0]      occ_raddr;
  logic [OCC_W-1:0]      occ_rdata;

  logic [VAL_W-1:0]      chk_start;
  logic [VAL_W:0]        chk_span_full;
  logic [OCC_W-1:0]      chk_span;
  logic [MEX_W-1:0]      mex_none;
  logic                  load_out;

  mmt_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_VALUES)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mmt_ram #(.WIDTH(OCC_W), .DEPTH(NUM_BLOCKS)) u_occ (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  assign clearing = state == S_CLEAR;
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign empty    = !out_valid;
  assign load_out = (state == S_DONE) && (!out_valid || pop);
  assign mex_none = {1'b0, value_limit} + MEX_W'(1);

  // span of the block under check, capped at the block size
  always_comb begin
    chk_start     = {blk_chk, {OFS_W{1'b0}}};
    chk_span_full = {1'b0, value_limit} - {1'b0, chk_start} + (VAL_W + 1)'(1);
    if (chk_span_full > (VAL_W + 1)'(VALS_PER_BLOCK)) begin
      chk_span = OCC_W'(VALS_PER_BLOCK);
    end else begin
      chk_span = chk_span_full[OCC_W-1:0];
    end
  end

  // memory port control
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = cur_val;
    cnt_wdata = '0;
    cnt_raddr = cmd.value;
    occ_we    = 1'b0;
    occ_waddr = cur_val[VAL_W-1:OFS_W];
    occ_wdata = '0;
    occ_raddr = cmd.value[VAL_W-1:OFS_W];
    case (state)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_cnt;
        occ_we    = int'(clr_cnt) < NUM_BLOCKS;
        occ_waddr = clr_cnt[BLK_W-1:0];
      end
      S_UPDATE: begin
        if (cur_op == CMD_ADD && cnt_rdata != COUNT_MAX) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata + COUNT_BITS'(1);
          occ_we    = cnt_rdata == '0;
          occ_wdata = occ_rdata + OCC_W'(1);
        end else if (cur_op == CMD_REMOVE && cnt_rdata != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata - COUNT_BITS'(1);
          occ_we    = cnt_rdata == COUNT_BITS'(1);
          occ_wdata = occ_rdata - OCC_W'(1);
        end
      end
      S_SCANB: begin
        occ_raddr = blk[BLK_W-1:0];
      end
      S_SCANV: begin
        cnt_raddr = {base, k[OFS_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else if (restart) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + VAL_W'(1);
          if (clr_cnt == VAL_W'(MAX_VALUES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op inside {CMD_ADD, CMD_REMOVE}) begin
              state <= S_UPDATE;
            end else begin
              state <= S_SCANB;
            end
          end
        end
        S_UPDATE: begin
          state <= S_SCANB;
        end
        S_SCANB: begin
          if (blk_chk_valid) begin
            if (chk_start > value_limit) begin
              state <= S_DONE;
            end else if (occ_rdata < chk_span) begin
              state <= S_SCANV;
            end else if (int'(blk_chk) == NUM_BLOCKS - 1) begin
              state <= S_DONE;
            end
          end
        end
        S_SCANV: begin
          if (k_chk_valid) begin
            if (cnt_rdata == '0 || k_chk == OFS_W'(span - OCC_W'(1))) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur_op        <= cmd.op;
        cur_val       <= cmd.value;
        blk           <= '0;
        blk_chk_valid <= 1'b0;
        status        <= (cmd.op == CMD_RANGE) ? STAT_RANGE : STAT_OK;
      end
      S_UPDATE: begin
        if (cur_op == CMD_ADD && cnt_rdata == COUNT_MAX) begin
          status <= STAT_SAT;
        end else if (cur_op == CMD_REMOVE && cnt_rdata == '0) begin
          status <= STAT_ABSENT;
        end
      end
      S_SCANB: begin
        blk_chk_valid <= int'(blk) < NUM_BLOCKS;
        blk_chk       <= blk[BLK_W-1:0];
        if (int'(blk) < NUM_BLOCKS) begin
          blk <= blk + (BLK_W + 1)'(1);
        end
        k           <= '0;
        k_chk_valid <= 1'b0;
        base        <= blk_chk;
        span        <= chk_span;
        mex         <= mex_none;
      end
      S_SCANV: begin
        k_chk_valid <= k < {1'b0, span};
        k_chk       <= k[OFS_W-1:0];
        if (k < {1'b0, span}) begin
          k <= k + (OCC_W + 1)'(1);
        end
        if (k_chk_valid && cnt_rdata == '0) begin
          mex <= MEX_W'({base, k_chk});
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_item.mex    <= mex;
      out_item.status <= status;
    end
  end

endmodule

FILE: design/multiset_mex_tracker_unit.sv
// multiset mex tracker: keeps one occurrence count per value 0..value_limit
// plus a count of present values per 32-value block, and answers every item
// (add, remove or query) with the smallest absent value after the operation
// and a status code. items go in through a push/full queue port and results
// come out through an empty/pop queue port, oldest first. in the back end an
// item is taken, an add or remove gets a read-modify-write of its count,
// then a pipelined scan of the block summaries (one per cycle, up to 32)
// and then a pipelined scan of the counts in the first block that is not
// full (one per cycle, up to 32) finds the smallest absent value, each scan
// bounded by the single read port of its store, and the result is posted.
// a waiting result that is not popped holds the back end. a two-entry
// command queue lets new items come in while one is being worked on. after
// reset and after every write of value_limit the count store is swept clean,
// and full stays high while it is.
// value_limit may only be written while the block is idle.
module multiset_mex_tracker_unit (
  input  logic                        clk,
  input  logic                        rst,
  // input item queue
  input  logic                        push,
  output logic                        full,
  input  mmt_pkg::in_item_t           in_item,
  // result queue
  output logic                        empty,
  input  logic                        pop,
  output mmt_pkg::out_item_t          out_item,
  // limit register
  input  logic                        cfg_we,
  input  logic [mmt_pkg::LIMIT_W-1:0] cfg_data
);
  import mmt_pkg::*;

  logic [VAL_W-1:0] value_limit;
  logic             clearing;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_take;

  // limit register, saturated to the size of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      value_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      value_limit <= clamp_limit(cfg_data);
    end
  end

  // front end: range check, action decode and command queue
  mmt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .value_limit (value_limit),
    .clearing    (clearing),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  // back end: store update, mex search and result register
  mmt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_we),
    .value_limit (value_limit),
    .clearing    (clearing),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item)
  );

endmodule
